// ===== rtl/core/decimal40_signed_add_sub_compare_defines.svh =====
// assertion macros shared by the decimal add/subtract/compare rtl
`ifndef DECIMAL40_SIGNED_ADD_SUB_COMPARE_DEFINES_SVH
`define DECIMAL40_SIGNED_ADD_SUB_COMPARE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define DEC40ASC_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define DEC40ASC_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dec40asc_pkg.sv =====
// types and constants for the 40-digit decimal add/subtract/compare block
package dec40asc_pkg;

	localparam int unsigned LIMB_W    = 30;
	localparam int unsigned NLO       = 4;
	localparam int unsigned TOP_W     = 15;
	localparam int unsigned RAW_TOP_W = 16;
	localparam int unsigned OUT_TOP_W = 14;
	localparam int unsigned B3T_W     = 44;
	localparam int unsigned QHI_W     = 15;
	localparam int unsigned RECIP_W   = 16;

	localparam logic [LIMB_W-1:0]    LIMB_BASE = 30'd1000000000;
	localparam logic [LIMB_W-1:0]    LIMB_MAX  = 30'd999999999;
	localparam logic [RAW_TOP_W-1:0] TOP_BASE  = 16'd10000;
	// 2^45 / 10^9 rounded down, applied to the top 15 bits of a 44-bit word
	localparam logic [RECIP_W-1:0]   RECIP     = 16'd35184;

	typedef logic [LIMB_W-1:0] limb_t;

	typedef struct packed {
		limb_t [NLO-1:0]  lo;
		logic [TOP_W-1:0] hi;
	} mag_t;

	typedef struct packed {
		logic greater;
		logic equal;
		logic less;
	} order_t;

	typedef struct packed {
		logic                 neg;
		limb_t [NLO-1:0]      lo;
		logic [RAW_TOP_W-1:0] hi;
	} raw_t;

	typedef struct packed {
		logic                 neg;
		limb_t [NLO-1:0]      lo;
		logic [OUT_TOP_W-1:0] hi;
		logic                 ovf;
		order_t               order;
	} res_t;

endpackage

// ===== rtl/core/decimal40_signed_add_sub_compare.sv =====
// top level: pipelined signed 40-digit decimal add/subtract with signed compare
// an accepted item is registered in each stage and then in the output register before result valid
// throughput: one item per cycle while the output is not stalled; depth is set by splitting b's top word by 10^9
//   (quotient estimate, then multiply-back remainder) ahead of the add/subtract stage
// stages advance independently, so bubbles collapse while the output is stalled
// reset: arst_n clears all valid bits at once; payload registers are not reset
module decimal40_signed_add_sub_compare (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   mode,
	input  logic                                   a_neg,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        a_limb0,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        a_limb1,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        a_limb2,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        a_limb3,
	input  logic [dec40asc_pkg::OUT_TOP_W-1:0]     a_limb4,
	input  logic                                   b_neg,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        b_limb0,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        b_limb1,
	input  logic [dec40asc_pkg::LIMB_W-1:0]        b_limb2,
	input  logic [dec40asc_pkg::B3T_W-1:0]         b_limb3_and_top,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   r_neg,
	output logic [dec40asc_pkg::LIMB_W-1:0]        r_limb0,
	output logic [dec40asc_pkg::LIMB_W-1:0]        r_limb1,
	output logic [dec40asc_pkg::LIMB_W-1:0]        r_limb2,
	output logic [dec40asc_pkg::LIMB_W-1:0]        r_limb3,
	output logic [dec40asc_pkg::OUT_TOP_W-1:0]     r_limb4,
	output logic                                   overflow,
	output logic                                   a_greater,
	output logic                                   a_equal,
	output logic                                   a_less
);

`include "decimal40_signed_add_sub_compare_defines.svh"

	localparam int unsigned LIMB_W    = dec40asc_pkg::LIMB_W;
	localparam int unsigned NLO       = dec40asc_pkg::NLO;
	localparam int unsigned TOP_W     = dec40asc_pkg::TOP_W;
	localparam int unsigned OUT_TOP_W = dec40asc_pkg::OUT_TOP_W;
	localparam int unsigned B3T_W     = dec40asc_pkg::B3T_W;
	localparam int unsigned QHI_W     = dec40asc_pkg::QHI_W;
	localparam int unsigned RECIP_W   = dec40asc_pkg::RECIP_W;
	localparam int unsigned QPROD_W   = QHI_W + RECIP_W;
	localparam int unsigned BPROD_W   = TOP_W + LIMB_W;
	localparam int unsigned REM_W     = LIMB_W + 1;

	// handshake: each stage takes a new item when empty or when it moves on
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic adv1, adv2, adv3, adv4, adv_out;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv4     = !v_s4 || adv_out;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
			if (adv_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// stage 1: input register
	logic                         mode_s1, a_neg_s1, b_neg_s1;
	dec40asc_pkg::limb_t [NLO-1:0] a_lo_s1;
	logic [OUT_TOP_W-1:0]         a_hi_s1;
	dec40asc_pkg::limb_t [NLO-2:0] b_lo_s1;
	logic [B3T_W-1:0]             b3t_s1;

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			mode_s1  <= mode;
			a_neg_s1 <= a_neg;
			b_neg_s1 <= b_neg;
			a_lo_s1  <= {a_limb3, a_limb2, a_limb1, a_limb0};
			a_hi_s1  <= a_limb4;
			b_lo_s1  <= {b_limb2, b_limb1, b_limb0};
			b3t_s1   <= b_limb3_and_top;
		end
	end

	// a: carry normalisation; b top word: quotient estimate, low by one at most
	dec40asc_pkg::mag_t   a_norm;
	logic [QPROD_W-1:0]   qprod;

	dec40asc_norm u_norm_a (
		.lo_raw (a_lo_s1),
		.hi_raw ({1'b0, a_hi_s1}),
		.mag    (a_norm)
	);

	assign qprod = QPROD_W'(b3t_s1[B3T_W-1 -: QHI_W]) * QPROD_W'(dec40asc_pkg::RECIP);

	// stage 2
	logic                         mode_s2, a_neg_s2, b_neg_s2;
	dec40asc_pkg::mag_t           a_mag_s2;
	dec40asc_pkg::limb_t [NLO-2:0] b_lo_s2;
	logic [B3T_W-1:0]             b3t_s2;
	logic [TOP_W-1:0]             q_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			mode_s2  <= mode_s1;
			a_neg_s2 <= a_neg_s1;
			b_neg_s2 <= b_neg_s1;
			a_mag_s2 <= a_norm;
			b_lo_s2  <= b_lo_s1;
			b3t_s2   <= b3t_s1;
			q_s2     <= qprod[QPROD_W-1 -: TOP_W];
		end
	end

	// remainder against the estimate, below 2 * 10^9
	logic [BPROD_W-1:0] bprod;
	logic [B3T_W-1:0]   rem_full;

	assign bprod    = BPROD_W'(q_s2) * BPROD_W'(dec40asc_pkg::LIMB_BASE);
	assign rem_full = b3t_s2 - bprod[B3T_W-1:0];

	// stage 3
	logic                         mode_s3, a_neg_s3, b_neg_s3;
	dec40asc_pkg::mag_t           a_mag_s3;
	dec40asc_pkg::limb_t [NLO-2:0] b_lo_s3;
	logic [REM_W-1:0]             rem_s3;
	logic [TOP_W-1:0]             q_s3;

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			mode_s3  <= mode_s2;
			a_neg_s3 <= a_neg_s2;
			b_neg_s3 <= b_neg_s2;
			a_mag_s3 <= a_mag_s2;
			b_lo_s3  <= b_lo_s2;
			rem_s3   <= rem_full[REM_W-1:0];
			q_s3     <= q_s2;
		end
	end

	// correct the estimate, then normalise b
	logic                          rem_fix;
	logic [REM_W-1:0]              rem_adj;
	dec40asc_pkg::limb_t [NLO-1:0] b_lo_raw;
	logic [TOP_W-1:0]              b_hi_raw;
	dec40asc_pkg::mag_t            b_norm;

	assign rem_fix  = (rem_s3 >= {1'b0, dec40asc_pkg::LIMB_BASE});
	assign rem_adj  = rem_fix ? (rem_s3 - {1'b0, dec40asc_pkg::LIMB_BASE}) : rem_s3;
	assign b_lo_raw = {rem_adj[LIMB_W-1:0], b_lo_s3};
	assign b_hi_raw = q_s3 + {{(TOP_W-1){1'b0}}, rem_fix};

	dec40asc_norm u_norm_b (
		.lo_raw (b_lo_raw),
		.hi_raw (b_hi_raw),
		.mag    (b_norm)
	);

	// stage 4
	logic               mode_s4, a_neg_s4, b_neg_s4;
	dec40asc_pkg::mag_t a_mag_s4, b_mag_s4;

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			mode_s4  <= mode_s3;
			a_neg_s4 <= a_neg_s3;
			b_neg_s4 <= b_neg_s3;
			a_mag_s4 <= a_mag_s3;
			b_mag_s4 <= b_norm;
		end
	end

	// compare, add or subtract, then wrap the top limb
	dec40asc_pkg::raw_t   raw;
	dec40asc_pkg::order_t order;
	dec40asc_pkg::res_t   res;

	dec40asc_arith u_arith (
		.mode  (mode_s4),
		.a_neg (a_neg_s4),
		.b_neg (b_neg_s4),
		.a_mag (a_mag_s4),
		.b_mag (b_mag_s4),
		.raw   (raw),
		.order (order)
	);

	dec40asc_wrap u_wrap (
		.raw   (raw),
		.order (order),
		.res   (res)
	);

	// output register, holds while the consumer stalls
	dec40asc_pkg::res_t res_q;

	always_ff @(posedge clk) begin
		if (adv_out && v_s4) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign r_neg     = res_q.neg;
	assign r_limb0   = res_q.lo[0];
	assign r_limb1   = res_q.lo[1];
	assign r_limb2   = res_q.lo[2];
	assign r_limb3   = res_q.lo[3];
	assign r_limb4   = res_q.hi;
	assign overflow  = res_q.ovf;
	assign a_greater = res_q.order.greater;
	assign a_equal   = res_q.order.equal;
	assign a_less    = res_q.order.less;

	// checks
	`DEC40ASC_CHECK_NOW(a_order_onehot, out_valid_q, $onehot({a_greater, a_equal, a_less}), "order flags not one-hot")
	`DEC40ASC_CHECK_NOW(a_zero_positive, out_valid_q && (res_q.lo == '0) && (r_limb4 == '0), !r_neg, "zero result marked negative")
	`DEC40ASC_CHECK_NOW(a_limbs_in_range, out_valid_q, (r_limb0 < dec40asc_pkg::LIMB_BASE) && (r_limb1 < dec40asc_pkg::LIMB_BASE) && (r_limb2 < dec40asc_pkg::LIMB_BASE) && (r_limb3 < dec40asc_pkg::LIMB_BASE) && ({2'b00, r_limb4} < dec40asc_pkg::TOP_BASE), "result limb out of range")
	`DEC40ASC_CHECK_NEXT(a_stage4_held, v_s4 && out_valid_q && out_stall, v_s4, "item in last stage lost under stall")
	`DEC40ASC_CHECK_NOW(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4 && out_valid_q, "input stalled with a free stage")

endmodule

// ===== rtl/core/dec40asc_norm.sv =====
// carry normalisation of a magnitude whose low limbs may exceed 10^9 - 1
module dec40asc_norm (
	input  dec40asc_pkg::limb_t [dec40asc_pkg::NLO-1:0] lo_raw,
	input  logic [dec40asc_pkg::TOP_W-1:0]              hi_raw,
	output dec40asc_pkg::mag_t                          mag
);

	localparam int unsigned NLO    = dec40asc_pkg::NLO;
	localparam int unsigned LIMB_W = dec40asc_pkg::LIMB_W;
	localparam int unsigned TOP_W  = dec40asc_pkg::TOP_W;

	logic [NLO:0]    carry;
	logic [LIMB_W:0] sum [NLO];

	// a 30-bit limb plus a carry stays below 2 * 10^9, so one carry out at most
	always_comb begin
		carry[0] = 1'b0;
		for (int i = 0; i < NLO; i++) begin
			carry[i+1] = (lo_raw[i] >= dec40asc_pkg::LIMB_BASE) ||
				((lo_raw[i] == dec40asc_pkg::LIMB_MAX) && carry[i]);
			sum[i] = {1'b0, lo_raw[i]} + {{LIMB_W{1'b0}}, carry[i]};
			if (carry[i+1]) begin
				sum[i] = sum[i] - {1'b0, dec40asc_pkg::LIMB_BASE};
			end
			mag.lo[i] = sum[i][LIMB_W-1:0];
		end
		mag.hi = hi_raw + {{(TOP_W-1){1'b0}}, carry[NLO]};
	end

endmodule

// ===== rtl/core/dec40asc_arith.sv =====
// magnitude compare, signed order and sign-magnitude add/subtract
module dec40asc_arith (
	input  logic                  mode,
	input  logic                  a_neg,
	input  logic                  b_neg,
	input  dec40asc_pkg::mag_t    a_mag,
	input  dec40asc_pkg::mag_t    b_mag,
	output dec40asc_pkg::raw_t    raw,
	output dec40asc_pkg::order_t  order
);

	localparam int unsigned NLO       = dec40asc_pkg::NLO;
	localparam int unsigned LIMB_W    = dec40asc_pkg::LIMB_W;
	localparam int unsigned RAW_TOP_W = dec40asc_pkg::RAW_TOP_W;

	typedef enum logic [1:0] {CMP_LT, CMP_EQ, CMP_GT} cmp_t;

	function automatic dec40asc_pkg::raw_t add_mag(input dec40asc_pkg::mag_t x,
			input dec40asc_pkg::mag_t y);
		dec40asc_pkg::raw_t r;
		logic               c;
		logic               co;
		logic [LIMB_W:0]    s;
		c = 1'b0;
		r.neg = 1'b0;
		for (int i = 0; i < NLO; i++) begin
			s  = {1'b0, x.lo[i]} + {1'b0, y.lo[i]};
			co = (s >= {1'b0, dec40asc_pkg::LIMB_BASE}) ||
				((s == {1'b0, dec40asc_pkg::LIMB_MAX}) && c);
			s  = s + {{LIMB_W{1'b0}}, c};
			if (co) begin
				s = s - {1'b0, dec40asc_pkg::LIMB_BASE};
			end
			r.lo[i] = s[LIMB_W-1:0];
			c = co;
		end
		r.hi = {1'b0, x.hi} + {1'b0, y.hi} + {{(RAW_TOP_W-1){1'b0}}, c};
		return r;
	endfunction

	// x is not below y, so the top difference never goes negative
	function automatic dec40asc_pkg::raw_t sub_mag(input dec40asc_pkg::mag_t x,
			input dec40asc_pkg::mag_t y);
		dec40asc_pkg::raw_t r;
		logic               c;
		logic               bo;
		logic [LIMB_W:0]    s;
		c = 1'b0;
		r.neg = 1'b0;
		for (int i = 0; i < NLO; i++) begin
			bo = (x.lo[i] < y.lo[i]) || ((x.lo[i] == y.lo[i]) && c);
			s  = {1'b0, x.lo[i]} - {1'b0, y.lo[i]} - {{LIMB_W{1'b0}}, c};
			if (bo) begin
				s = s + {1'b0, dec40asc_pkg::LIMB_BASE};
			end
			r.lo[i] = s[LIMB_W-1:0];
			c = bo;
		end
		r.hi = {1'b0, x.hi} - {1'b0, y.hi} - {{(RAW_TOP_W-1){1'b0}}, c};
		return r;
	endfunction

	logic               a_zero;
	logic               b_zero;
	logic               an;
	logic               bn;
	logic               bs;
	cmp_t               mcmp;
	dec40asc_pkg::raw_t sum_r;
	dec40asc_pkg::raw_t a_minus_b;
	dec40asc_pkg::raw_t b_minus_a;

	assign a_zero = (a_mag == '0);
	assign b_zero = (b_mag == '0);
	// negative zero counts as positive
	assign an = a_neg && !a_zero;
	assign bn = b_neg && !b_zero;
	assign bs = (b_neg ^ mode) && !b_zero;

	// magnitude compare, higher limbs override lower ones
	always_comb begin
		mcmp = CMP_EQ;
		for (int i = 0; i < NLO; i++) begin
			if (a_mag.lo[i] > b_mag.lo[i]) begin
				mcmp = CMP_GT;
			end else if (a_mag.lo[i] < b_mag.lo[i]) begin
				mcmp = CMP_LT;
			end
		end
		if (a_mag.hi > b_mag.hi) begin
			mcmp = CMP_GT;
		end else if (a_mag.hi < b_mag.hi) begin
			mcmp = CMP_LT;
		end
	end

	always_comb begin
		if (an != bn) begin
			order.greater = !an;
			order.equal   = 1'b0;
			order.less    = an;
		end else begin
			order.equal   = (mcmp == CMP_EQ);
			order.greater = an ? (mcmp == CMP_LT) : (mcmp == CMP_GT);
			order.less    = an ? (mcmp == CMP_GT) : (mcmp == CMP_LT);
		end
	end

	assign sum_r     = add_mag(a_mag, b_mag);
	assign a_minus_b = sub_mag(a_mag, b_mag);
	assign b_minus_a = sub_mag(b_mag, a_mag);

	always_comb begin
		if (an == bs) begin
			raw     = sum_r;
			raw.neg = an;
		end else if (mcmp != CMP_LT) begin
			raw     = a_minus_b;
			raw.neg = an;
		end else begin
			raw     = b_minus_a;
			raw.neg = bs;
		end
	end

endmodule

// ===== rtl/core/dec40asc_wrap.sv =====
// top limb wrap modulo 10^4, overflow flag and sign of zero
module dec40asc_wrap (
	input  dec40asc_pkg::raw_t   raw,
	input  dec40asc_pkg::order_t order,
	output dec40asc_pkg::res_t   res
);

	localparam int unsigned RAW_TOP_W = dec40asc_pkg::RAW_TOP_W;
	localparam int unsigned OUT_TOP_W = dec40asc_pkg::OUT_TOP_W;
	localparam logic [RAW_TOP_W-1:0] TOP_X2 = RAW_TOP_W'(2 * dec40asc_pkg::TOP_BASE);
	localparam logic [RAW_TOP_W-1:0] TOP_X3 = RAW_TOP_W'(3 * dec40asc_pkg::TOP_BASE);

	logic [RAW_TOP_W-1:0] hi_w;

	// raw top limb stays below 4 * 10^4 (largest sum of two normalised tops)
	always_comb begin
		if (raw.hi >= TOP_X3) begin
			hi_w = raw.hi - TOP_X3;
		end else if (raw.hi >= TOP_X2) begin
			hi_w = raw.hi - TOP_X2;
		end else if (raw.hi >= dec40asc_pkg::TOP_BASE) begin
			hi_w = raw.hi - dec40asc_pkg::TOP_BASE;
		end else begin
			hi_w = raw.hi;
		end
	end

	always_comb begin
		res.lo    = raw.lo;
		res.hi    = hi_w[OUT_TOP_W-1:0];
		res.ovf   = (raw.hi >= dec40asc_pkg::TOP_BASE);
		res.order = order;
		res.neg   = raw.neg && !((raw.lo == '0) && (hi_w == '0));
	end

endmodule
